[hdl/sita_pkg.sv]
`default_nettype none
package sita_pkg;

  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 31;
  localparam int CHAR_W       = 8;
  localparam int DIGITS       = 10;
  localparam int DIGIT_W      = 4;
  localparam int BCD_W        = DIGITS * DIGIT_W;
  localparam int IDX_W        = $clog2(DIGITS);
  localparam int DABBLE_BITS  = 4;
  localparam int DABBLE_STEPS = VALUE_W / DABBLE_BITS;
  localparam int STEP_W       = $clog2(DABBLE_STEPS);

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

  // One converted number waiting for emission.
  typedef struct packed {
    logic               negative;
    logic [BCD_W-1:0]   bcd;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_SIGN  = 3'b010,
    B_DIGIT = 3'b100
  } back_state_t;

  function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] c);
    count_inc = (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage
`default_nettype wire

[hdl/sita_front.sv]
`default_nettype none
module sita_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [sita_pkg::VALUE_W-1:0]    value,
  input  wire logic [sita_pkg::COUNT_W-1:0]    count_in,
  output logic                                 push,
  output sita_pkg::entry_t                     push_data,
  input  wire logic                            full
);
  import sita_pkg::*;

  localparam int WORK_W = BCD_W + VALUE_W;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DABBLE_STEPS - 1);

  front_state_t       state, state_next;
  logic [WORK_W-1:0]  work, work_next;
  logic [STEP_W-1:0]  step;
  logic               negative;
  logic [COUNT_W-1:0] count;

  // One shift-and-add-3 step over all digits.
  function automatic logic [WORK_W-1:0] dabble(input logic [WORK_W-1:0] w);
    logic [WORK_W-1:0] t;
    t = w;
    for (int i = 0; i < DIGITS; i++) begin
      if (t[VALUE_W + DIGIT_W*i +: DIGIT_W] >= DIGIT_W'(5)) begin
        t[VALUE_W + DIGIT_W*i +: DIGIT_W] = t[VALUE_W + DIGIT_W*i +: DIGIT_W] + DIGIT_W'(3);
      end
    end
    dabble = t << 1;
  endfunction

  always_comb begin
    work_next = work;
    for (int b = 0; b < DABBLE_BITS; b++) begin
      work_next = dabble(work_next);
    end
  end

  assign busy = (state != F_IDLE);
  assign push = (state == F_PUSH) && !full;

  assign push_data.negative = negative;
  assign push_data.bcd      = work[WORK_W-1 -: BCD_W];
  assign push_data.count    = count;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (start) state_next = F_CONV;
      F_CONV: if (step == LAST_STEP) state_next = F_PUSH;
      F_PUSH: if (!full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && start) begin
      negative <= value[VALUE_W-1];
      count    <= count_in;
      step     <= '0;
      // magnitude taken unsigned, so the most negative value stays exact
      work     <= {{BCD_W{1'b0}}, (value[VALUE_W-1] ? (~value + 1'b1) : value)};
    end else if (state == F_CONV) begin
      work <= work_next;
      step <= step + 1'b1;
    end
  end

endmodule
`default_nettype wire

[hdl/sita_queue.sv]
`default_nettype none
module sita_queue #(
  parameter int DEPTH = sita_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sita_pkg::entry_t  push_data,
  output logic                   full,
  input  wire logic              pop,
  output sita_pkg::entry_t       pop_data,
  output logic                   empty
);
  import sita_pkg::*;

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [FILL_W-1:0]  fill;
  logic               do_push, do_pop;

  assign full     = (fill == FILL_MAX);
  assign empty    = (fill == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

[hdl/sita_back.sv]
`default_nettype none
module sita_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           empty,
  input  wire sita_pkg::entry_t               pop_data,
  output logic                                pop,
  output logic                                strobe,
  output logic [sita_pkg::CHAR_W-1:0]         character,
  output logic                                last_char,
  output logic [sita_pkg::COUNT_W-1:0]        count_out
);
  import sita_pkg::*;

  back_state_t        state, state_next;
  logic [BCD_W-1:0]   bcd;
  logic [COUNT_W-1:0] count;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   top_idx;
  logic [DIGIT_W-1:0] digit;

  // Highest nonzero digit; zero keeps index 0 so one '0' goes out.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (pop_data.bcd[DIGIT_W*i +: DIGIT_W] != '0) top_idx = IDX_W'(i);
    end
  end

  assign pop   = (state == B_IDLE) && !empty;
  assign digit = bcd[DIGIT_W*idx +: DIGIT_W];

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (!empty) state_next = pop_data.negative ? B_SIGN : B_DIGIT;
      B_SIGN:  state_next = B_DIGIT;
      B_DIGIT: if (idx == '0) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == B_SIGN) || (state == B_DIGIT);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (!empty) begin
          bcd   <= pop_data.bcd;
          count <= pop_data.count;
          idx   <= top_idx;
        end
      end
      B_SIGN: begin
        character <= CHAR_MINUS;
        last_char <= 1'b0;
        count_out <= count_inc(count);
        count     <= count_inc(count);
      end
      B_DIGIT: begin
        character <= CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
        last_char <= (idx == '0);
        count_out <= count_inc(count);
        count     <= count_inc(count);
        // advance toward the least significant digit
        if (idx != '0) idx <= idx - 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last_char |=> !strobe)
    else $error("word followed the last character of a number");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_char |=> strobe)
    else $error("gap inside the text of a number");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_char |=> count_out == count_inc($past(count_out)))
    else $error("running count did not advance by one");

  a_minus_first: assert property (@(posedge clk) disable iff (rst)
    strobe && character == CHAR_MINUS |-> !last_char && !$past(strobe))
    else $error("minus sign out of place");

endmodule
`default_nettype wire

[hdl/signed_int_to_decimal_ascii.sv]
`default_nettype none
// Channel   Ports                              Handshake
// input     value, count_in                    start high and busy low at clk edge
// result    character, last_char, count_out    strobe high for one cycle
//
// The front takes a number, forms its magnitude and converts it to BCD, four
// bits per cycle; busy stays high until the result is pushed into the queue,
// and that push waits while the queue is full.
// The back takes a word from the queue, then emits one character per cycle.
// The queue lets the front convert a new number while the back still emits
// the last one; the slower of the two sides sets the sustained rate.
// rst is synchronous, active high, and empties the queue.
// Results cannot be stalled: each word holds for exactly one cycle.
module signed_int_to_decimal_ascii #(
  parameter int QUEUE_DEPTH = sita_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [sita_pkg::VALUE_W-1:0]    value,
  input  wire logic [sita_pkg::COUNT_W-1:0]    count_in,
  output logic                                 strobe,
  output logic [sita_pkg::CHAR_W-1:0]          character,
  output logic                                 last_char,
  output logic [sita_pkg::COUNT_W-1:0]         count_out
);
  import sita_pkg::*;

  entry_t push_data, pop_data;
  logic   push, full, pop, empty;

  sita_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .count_in  (count_in),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  sita_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  sita_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .strobe    (strobe),
    .character (character),
    .last_char (last_char),
    .count_out (count_out)
  );

endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

import sita_pkg::*;

typedef struct {
  logic [CHAR_W-1:0]  character;
  logic               last_char;
  logic [COUNT_W-1:0] count_out;
} char_word_t;

// Spells each accepted number into the characters it must produce and
// checks emitted characters against them in order.
class decimal_text_board;
  char_word_t pending_chars[$];
  int errors;
  int numbers_seen;
  int chars_seen;

  function new();
    errors = 0;
    numbers_seen = 0;
    chars_seen = 0;
  endfunction

  function void note_number(logic [VALUE_W-1:0] v, logic [COUNT_W-1:0] c);
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  digits [DIGITS];
    logic [CHAR_W-1:0]  text [DIGITS+1];
    logic [COUNT_W-1:0] cnt;
    char_word_t         w;
    int                 ndig;
    int                 len;
    int                 k;
    bit                 neg;
    neg = v[VALUE_W-1];
    // magnitude as unsigned, so the most negative value still fits
    mag = neg ? (~v + 1'b1) : v;
    ndig = 0;
    do begin
      digits[ndig] = CHAR_ZERO + 8'(mag % 10);
      ndig++;
      mag = mag / 10;
    end while (mag != 0 && ndig < DIGITS);
    len = 0;
    if (neg) begin
      text[len] = CHAR_MINUS;
      len++;
    end
    for (k = ndig - 1; k >= 0; k--) begin
      text[len] = digits[k];
      len++;
    end
    cnt = c;
    for (k = 0; k < len; k++) begin
      if (cnt != COUNT_MAX) cnt = cnt + 1'b1;
      w.character = text[k];
      w.last_char = (k == len - 1);
      w.count_out = cnt;
      pending_chars.push_back(w);
    end
    numbers_seen++;
  endfunction

  function void check_char(logic [CHAR_W-1:0] ch, logic last, logic [COUNT_W-1:0] cnt);
    char_word_t w;
    chars_seen++;
    if (pending_chars.size() == 0) begin
      $display("%0t: unexpected word: character %0d last_char %0d count_out %0d",
               $time, ch, last, cnt);
      errors++;
    end else begin
      w = pending_chars.pop_front();
      if (ch !== w.character) begin
        $display("%0t: character: expected %0d, actual %0d", $time, w.character, ch);
        errors++;
      end
      if (last !== w.last_char) begin
        $display("%0t: last_char: expected %0d, actual %0d", $time, w.last_char, last);
        errors++;
      end
      if (cnt !== w.count_out) begin
        $display("%0t: count_out: expected %0d, actual %0d", $time, w.count_out, cnt);
        errors++;
      end
    end
  endfunction
endclass

module testbench;
  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] count_in;
  logic               strobe;
  logic [CHAR_W-1:0]  character;
  logic               last_char;
  logic [COUNT_W-1:0] count_out;

  decimal_text_board board;

  signed_int_to_decimal_ascii DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .count_in  (count_in),
    .strobe    (strobe),
    .character (character),
    .last_char (last_char),
    .count_out (count_out)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && strobe) board.check_char(character, last_char, count_out);
  end

  // Hold start high until the word is taken; start stays up for the caller.
  task automatic send_number(logic [VALUE_W-1:0] v, logic [COUNT_W-1:0] c);
    @(negedge clk);
    start    <= 1'b1;
    value    <= v;
    count_in <= c;
    do @(posedge clk); while (busy);
    board.note_number(v, c);
  endtask

  task automatic idle_gap(int pct);
    while ($urandom_range(0, 99) < pct) begin
      @(negedge clk);
      start    <= 1'b0;
      value    <= $urandom;
      count_in <= COUNT_W'($urandom);
    end
  endtask

  task automatic run_phase(int pct, int n);
    logic [VALUE_W-1:0] v;
    logic [COUNT_W-1:0] c;
    longint unsigned    lim;
    int                 k;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: begin
          // random length, so short numbers show up often
          lim = 1;
          repeat ($urandom_range(1, 10)) lim = lim * 10;
          v = VALUE_W'(longint'($urandom) % lim);
          if ($urandom_range(0, 1)) v = -v;
        end
        2: begin
          lim = 1;
          k = $urandom_range(0, 9);
          repeat (k) lim = lim * 10;
          v = VALUE_W'(lim) + VALUE_W'($urandom_range(0, 2)) - 1'b1;
          if ($urandom_range(0, 1)) v = -v;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: v = '0;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h8000_0000;
            default: v = 32'h8000_0001;
          endcase
        end
      endcase
      case ($urandom_range(0, 3))
        0, 1: c = COUNT_W'($urandom);
        2: c = COUNT_MAX - COUNT_W'($urandom_range(0, 12));
        default: c = COUNT_W'($urandom_range(0, 20));
      endcase
      send_number(v, c);
      idle_gap(pct);
    end
  endtask

  initial begin
    board    = new();
    rst      = 1'b1;
    start    = 1'b0;
    value    = '0;
    count_in = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero, extremes, digit-count boundaries, count saturation
    send_number(32'd0, 31'd0);
    send_number(32'd0, COUNT_MAX);
    send_number(32'd1, 31'd0);
    send_number(-32'sd1, 31'd5);
    send_number(32'd9, 31'd100);
    send_number(32'd10, 31'd0);
    send_number(-32'sd10, 31'd7);
    send_number(32'h7FFF_FFFF, 31'd0);
    send_number(32'h8000_0000, 31'd0);
    send_number(32'h8000_0000, COUNT_MAX - 31'd5);
    send_number(32'h8000_0001, COUNT_MAX - 31'd11);
    send_number(32'd1000000000, COUNT_MAX - 31'd1);
    send_number(32'd999999999, COUNT_MAX);
    send_number(-32'sd999999999, 31'h2AAA_AAAA);
    idle_gap(50);
    send_number(32'd123456789, 31'h5555_5555);
    send_number(-32'sd1000000000, COUNT_MAX - 31'd10);
    send_number(32'd4294967295, 31'd1);
    send_number(32'd5, COUNT_MAX - 31'd1);
    idle_gap(50);

    run_phase(12, 120);
    run_phase(64, 120);
    run_phase(0, 110);
    @(negedge clk);
    start <= 1'b0;

    while (board.pending_chars.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d numbers, %0d characters checked", board.numbers_seen,
             board.chars_seen);
    $display("zero, extremes, digit boundaries and count saturation included");
    if (board.errors == 0 && board.pending_chars.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d words outstanding", board.pending_chars.size());
    $display("end of test: mismatches");
    $finish;
  end
endmodule
